// ===== hdl/abp_pkg.sv =====
`default_nettype none

package abp_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_OUTPUT_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_OUTPUT_HEIGHT = 2'd1;

  localparam logic [15:0] OUTPUT_WIDTH_RST  = 16'd1920;
  localparam logic [15:0] OUTPUT_HEIGHT_RST = 16'd1080;

  // zone value that selects the full output as bounds
  localparam logic [15:0] ZONE_FULL = 16'hFFFF;

  localparam int unsigned ANC_TOP    = 0;
  localparam int unsigned ANC_BOTTOM = 1;
  localparam int unsigned ANC_LEFT   = 2;
  localparam int unsigned ANC_RIGHT  = 3;

  typedef struct packed {
    logic near;
    logic far;
  } axis_ctrl_t;

  typedef struct packed {
    logic apply;
    logic top3;    // left, right, top
    logic bot3;    // left, right, bottom
    logic left3;   // left, top, bottom
    logic right3;  // right, top, bottom
  } area_upd_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] w;
    logic [31:0] h;
  } area_t;

  // two's complement halving, truncating toward zero
  function automatic logic [31:0] half_tz(input logic [31:0] v);
    logic [31:0] n;
    n = 32'd0 - v;
    half_tz = v[31] ? (32'd0 - {1'b0, n[31:1]}) : {1'b0, v[31:1]};
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/abp_axis.sv =====
`default_nettype none

module abp_axis import abp_pkg::*; (
  input  axis_ctrl_t  ctrl_i,
  input  logic [31:0] bound_pos_i,
  input  logic [31:0] bound_size_i,
  input  logic [15:0] want_i,
  input  logic [15:0] margin_near_i,
  input  logic [15:0] margin_far_i,
  output logic [31:0] pos_o,
  output logic [31:0] size_o
);

  logic [31:0] want32;
  logic [31:0] mn;
  logic [31:0] mf;
  logic [31:0] pos0;
  logic [31:0] size0;
  logic        stretch;

  assign want32  = {16'd0, want_i};
  assign mn      = sext16(margin_near_i);
  assign mf      = sext16(margin_far_i);
  assign stretch = (ctrl_i.near | ctrl_i.far) & (want_i == 16'd0);

  always_comb begin
    size0 = stretch ? bound_size_i : want32;
    if (stretch || ctrl_i.near) begin
      pos0 = bound_pos_i;
    end else if (ctrl_i.far) begin
      pos0 = bound_pos_i + (bound_size_i - want32);
    end else begin
      pos0 = bound_pos_i + (half_tz(bound_size_i) - {1'b0, want32[31:1]});
    end

    pos_o  = pos0;
    size_o = size0;
    if (ctrl_i.near && ctrl_i.far) begin
      pos_o  = pos0 + mn;
      size_o = size0 - (mn + mf);
    end else if (ctrl_i.near) begin
      pos_o = pos0 + mn;
    end else if (ctrl_i.far) begin
      pos_o = pos0 - mf;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/abp_area.sv =====
`default_nettype none

module abp_area import abp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        restart_i,
  input  logic [15:0] output_width_i,
  input  logic [15:0] output_height_i,
  input  area_upd_t   upd_i,
  input  logic [15:0] zone_i,
  input  logic [15:0] margin_up_i,
  input  logic [15:0] margin_rt_i,
  input  logic [15:0] margin_down_i,
  input  logic [15:0] margin_lf_i,
  output area_t       eff_o,
  output area_t       nxt_o
);

  area_t       usable_q;
  logic [31:0] zone32;
  logic [31:0] dz_up;
  logic [31:0] dz_down;
  logic [31:0] dz_lf;
  logic [31:0] dz_rt;

  assign zone32 = sext16(zone_i);

  always_comb begin
    if (restart_i) begin
      eff_o.x = 32'd0;
      eff_o.y = 32'd0;
      eff_o.w = {16'd0, output_width_i};
      eff_o.h = {16'd0, output_height_i};
    end else begin
      eff_o = usable_q;
    end

    dz_up   = (upd_i.apply && upd_i.top3)   ? zone32 + sext16(margin_up_i)   : 32'd0;
    dz_down = (upd_i.apply && upd_i.bot3)   ? zone32 + sext16(margin_down_i) : 32'd0;
    dz_lf   = (upd_i.apply && upd_i.left3)  ? zone32 + sext16(margin_lf_i)   : 32'd0;
    dz_rt   = (upd_i.apply && upd_i.right3) ? zone32 + sext16(margin_rt_i)   : 32'd0;

    nxt_o.x = eff_o.x + dz_lf;
    nxt_o.y = eff_o.y + dz_up;
    nxt_o.w = eff_o.w - dz_lf - dz_rt;
    nxt_o.h = eff_o.h - dz_up - dz_down;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q.x <= 32'd0;
      usable_q.y <= 32'd0;
      usable_q.w <= {16'd0, OUTPUT_WIDTH_RST};
      usable_q.h <= {16'd0, OUTPUT_HEIGHT_RST};
    end else if (en_i) begin
      usable_q <= nxt_o;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/anchored_box_placer_top.sv =====
`default_nettype none

// Channel  Direction  Handshake                Payload
// in       sink       in_valid_i / in_ready_o   restart_i .. margin_lf_i
// out      source     out_valid_o / out_ready_i placed_o, box_*_o, area_*_o
// cfg      sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// One request per cycle while out_ready_i is high (input register, then
// result register). The usable area register is updated in the same single
// logic pass that places the box, so back-to-back requests see it at once.
// Reset: usable area (0, 0, 1920, 1080), output size 1920 x 1080, pipe empty.
// A stalled result holds; the input register still accepts while it is empty,
// or while the result register is empty or being drained.

module anchored_box_placer_top import abp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                restart_i,
  input  logic                exclusive_pass_i,
  input  logic [3:0]          anchor_i,
  input  logic signed [15:0]  zone_i,
  input  logic [15:0]         want_width_i,
  input  logic [15:0]         want_height_i,
  input  logic signed [15:0]  margin_up_i,
  input  logic signed [15:0]  margin_rt_i,
  input  logic signed [15:0]  margin_down_i,
  input  logic signed [15:0]  margin_lf_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                placed_o,
  output logic signed [31:0]  box_x_o,
  output logic signed [31:0]  box_y_o,
  output logic signed [31:0]  box_width_o,
  output logic signed [31:0]  box_height_o,
  output logic signed [31:0]  area_x_o,
  output logic signed [31:0]  area_y_o,
  output logic signed [31:0]  area_width_o,
  output logic signed [31:0]  area_height_o
);

  logic [15:0] output_width_q;
  logic [15:0] output_height_q;

  logic        s1_valid_q;
  logic        restart_q;
  logic        pass_q;
  logic [3:0]  anchor_q;
  logic [15:0] zone_q;
  logic [15:0] want_w_q;
  logic [15:0] want_h_q;
  logic [15:0] mu_q;
  logic [15:0] mr_q;
  logic [15:0] md_q;
  logic [15:0] ml_q;

  logic        out_valid_q;
  logic        placed_q;
  area_t       box_q;
  area_t       area_q;

  logic        s1_adv;
  logic        in_acc;
  logic        zpos;
  logic        go;
  logic        placed_d;
  area_t       eff;
  area_t       nxt;
  logic [31:0] bx, by, bw, bh;
  logic [31:0] px, py, pw, ph;
  axis_ctrl_t  hctrl;
  axis_ctrl_t  vctrl;
  area_upd_t   upd;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_width_q  <= OUTPUT_WIDTH_RST;
      output_height_q <= OUTPUT_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_OUTPUT_WIDTH:  output_width_q  <= cfg_data_i;
        REG_OUTPUT_HEIGHT: output_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign in_acc     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      restart_q <= restart_i;
      pass_q    <= exclusive_pass_i;
      anchor_q  <= anchor_i;
      zone_q    <= zone_i;
      want_w_q  <= want_width_i;
      want_h_q  <= want_height_i;
      mu_q      <= margin_up_i;
      mr_q      <= margin_rt_i;
      md_q      <= margin_down_i;
      ml_q      <= margin_lf_i;
    end
  end

  assign zpos = ~zone_q[15] & (zone_q != 16'd0);
  assign go   = (pass_q == zpos);

  always_comb begin
    if (zone_q == ZONE_FULL) begin
      bx = 32'd0;
      by = 32'd0;
      bw = {16'd0, output_width_q};
      bh = {16'd0, output_height_q};
    end else begin
      bx = eff.x;
      by = eff.y;
      bw = eff.w;
      bh = eff.h;
    end
  end

  assign hctrl.near = anchor_q[ANC_LEFT];
  assign hctrl.far  = anchor_q[ANC_RIGHT];
  assign vctrl.near = anchor_q[ANC_TOP];
  assign vctrl.far  = anchor_q[ANC_BOTTOM];

  abp_axis u_axis_h (
    .ctrl_i        (hctrl),
    .bound_pos_i   (bx),
    .bound_size_i  (bw),
    .want_i        (want_w_q),
    .margin_near_i (ml_q),
    .margin_far_i  (mr_q),
    .pos_o         (px),
    .size_o        (pw)
  );

  abp_axis u_axis_v (
    .ctrl_i        (vctrl),
    .bound_pos_i   (by),
    .bound_size_i  (bh),
    .want_i        (want_h_q),
    .margin_near_i (mu_q),
    .margin_far_i  (md_q),
    .pos_o         (py),
    .size_o        (ph)
  );

  assign placed_d   = go & ~pw[31] & ~ph[31];
  assign upd.apply  = placed_d & zpos;
  assign upd.top3   = anchor_q[ANC_LEFT] & anchor_q[ANC_RIGHT] & anchor_q[ANC_TOP];
  assign upd.bot3   = anchor_q[ANC_LEFT] & anchor_q[ANC_RIGHT] & anchor_q[ANC_BOTTOM];
  assign upd.left3  = anchor_q[ANC_LEFT] & anchor_q[ANC_TOP] & anchor_q[ANC_BOTTOM];
  assign upd.right3 = anchor_q[ANC_RIGHT] & anchor_q[ANC_TOP] & anchor_q[ANC_BOTTOM];

  abp_area u_area (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (s1_adv),
    .restart_i       (restart_q),
    .output_width_i  (output_width_q),
    .output_height_i (output_height_q),
    .upd_i           (upd),
    .zone_i          (zone_q),
    .margin_up_i     (mu_q),
    .margin_rt_i     (mr_q),
    .margin_down_i   (md_q),
    .margin_lf_i     (ml_q),
    .eff_o           (eff),
    .nxt_o           (nxt)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      placed_q <= placed_d;
      box_q.x  <= placed_d ? px : 32'd0;
      box_q.y  <= placed_d ? py : 32'd0;
      box_q.w  <= placed_d ? pw : 32'd0;
      box_q.h  <= placed_d ? ph : 32'd0;
      area_q   <= nxt;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign placed_o      = placed_q;
  assign box_x_o       = box_q.x;
  assign box_y_o       = box_q.y;
  assign box_width_o   = box_q.w;
  assign box_height_o  = box_q.h;
  assign area_x_o      = area_q.x;
  assign area_y_o      = area_q.y;
  assign area_width_o  = area_q.w;
  assign area_height_o = area_q.h;

  a_skip_zero_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !placed_o |-> box_x_o == 0 && box_y_o == 0 &&
                                 box_width_o == 0 && box_height_o == 0)
    else $error("unplaced result carries a nonzero box");

  a_placed_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && placed_o |-> !box_width_o[31] && !box_height_o[31])
    else $error("placed box has negative size");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_no_state_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(area_x_o) && $stable(area_width_o))
    else $error("result changed while stalled");

endmodule

`default_nettype wire
